[rtl/core/u16u8_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

   localparam int QueueDepthDefault = 2;
   localparam int MaxBytes = 6;

   localparam logic [7:0] Lead4Byte = 8'hF0;
   localparam logic [7:0] Lead3Byte = 8'hE0;
   localparam logic [7:0] Lead2Byte = 8'hC0;
   localparam logic [7:0] ContByte  = 8'h80;

   localparam logic [5:0] HighSurrTag = 6'b110110;
   localparam logic [5:0] LowSurrTag  = 6'b110111;
   localparam logic [20:0] SuppBase   = 21'h10000;

   // One classified unit: up to six bytes in output order.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [2:0]               count;
      logic                     last;
   } job_type;

endpackage
`default_nettype wire

[rtl/core/u16u8_front.sv]
// Front end: accepts code units, tracks a held high surrogate, builds byte jobs.
`default_nettype none
module u16u8_front
   import u16u8_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_last_unit,
   input  wire logic        queue_full,
   output logic             req_stall,
   output logic             push,
   output job_type          push_job
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;

   logic            accept;
   logic            is_high, is_low;
   logic [20:0]     pair_cp;
   logic [15:0]     held_unit;
   logic [2:0][7:0] new_bytes;
   logic [2:0]      new_count;
   logic            new_hold;

   function automatic logic [2:0][7:0] enc3(input logic [15:0] ch);
      logic [2:0][7:0] b;
      b[0] = Lead3Byte | {4'b0, ch[15:12]};
      b[1] = ContByte  | {2'b0, ch[11:6]};
      b[2] = ContByte  | {2'b0, ch[5:0]};
      return b;
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && (push_job.count != 3'd0);

   always_comb begin
      is_high   = (req_code_unit[15:10] == HighSurrTag);
      is_low    = (req_code_unit[15:10] == LowSurrTag);
      pair_cp   = SuppBase + {1'b0, held_bits_ff, req_code_unit[9:0]};
      held_unit = {HighSurrTag, held_bits_ff};
      new_hold  = 1'b0;
      new_bytes = '0;

      if (req_code_unit < 16'h0080) begin
         new_bytes[0] = {1'b0, req_code_unit[6:0]};
         new_count    = 3'd1;
      end else if (req_code_unit < 16'h0800) begin
         new_bytes[0] = Lead2Byte | {3'b0, req_code_unit[10:6]};
         new_bytes[1] = ContByte  | {2'b0, req_code_unit[5:0]};
         new_count    = 3'd2;
      end else if (is_high && !req_last_unit) begin
         new_count = 3'd0;
         new_hold  = 1'b1;
      end else begin
         new_bytes = enc3(req_code_unit);
         new_count = 3'd3;
      end

      push_job.bytes = '0;
      push_job.last  = req_last_unit;
      if (held_valid_ff && is_low) begin
         push_job.bytes[0] = Lead4Byte | {5'b0, pair_cp[20:18]};
         push_job.bytes[1] = ContByte  | {2'b0, pair_cp[17:12]};
         push_job.bytes[2] = ContByte  | {2'b0, pair_cp[11:6]};
         push_job.bytes[3] = ContByte  | {2'b0, pair_cp[5:0]};
         push_job.count    = 3'd4;
      end else if (held_valid_ff) begin
         // The held surrogate is unpaired: flush it ahead of this unit.
         push_job.bytes[2:0] = enc3(held_unit);
         push_job.bytes[5:3] = new_bytes;
         push_job.count      = 3'd3 + new_count;
      end else begin
         push_job.bytes[2:0] = new_bytes;
         push_job.count      = new_count;
      end
   end

   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         if (new_hold && !(held_valid_ff && is_low)) begin
            held_valid_in = 1'b1;
            held_bits_in  = req_code_unit[9:0];
         end else begin
            held_valid_in = 1'b0;
            held_bits_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/u16u8_queue.sv]
// Small job queue between the front end and the byte serializer.
`default_nettype none
module u16u8_queue
   import u16u8_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   job_type         mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/u16u8_back.sv]
// Back end: walks the head job one byte per cycle into the output register while the receiver does not stall.
`default_nettype none
module u16u8_back
   import u16u8_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_run_last,
   output logic         rsp_string_end
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_last_ff, string_end_ff;
   logic       advance, fin;

   assign advance = head_valid && (!valid_ff || !rsp_stall);
   assign fin     = (idx_ff == head_job.count - 3'd1);
   assign pop     = advance && fin;

   always_comb begin
      idx_in = idx_ff;
      if (advance) begin
         idx_in = fin ? 3'd0 : idx_ff + 3'd1;
      end
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff       <= head_job.bytes[idx_ff];
         run_last_ff   <= fin;
         string_end_ff <= fin && head_job.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = string_end_ff;

endmodule
`default_nettype wire

[rtl/core/utf16_to_utf8_transcoder_top.sv]
// UTF-16 to UTF-8 transcoder top level.
//
// Input channel (req_): one 16-bit code unit per beat plus a flag for the last
// unit of a string. Output channel (rsp_): one UTF-8 byte per beat, with
// run_last on the final byte caused by an input unit and string_end on the
// final byte of the string. A high surrogate that is not the last unit of its
// string produces no bytes until the next unit shows whether it is paired; an
// unpaired one is flushed as three bytes. The front end classifies each unit
// combinationally and queues a job of up to six bytes; the back end sends one
// byte per cycle from the queue head while the receiver does not stall.
// Each accepted job is written into the queue; its bytes then pass from the
// queue head through the output register. A unit gives up to four bytes (up to
// six when a held surrogate is flushed). The front end stalls only when the job
// queue is full. Reset clears the held surrogate, the queue and the output
// valid flag. When the receiver stalls, the current byte holds on the rsp_
// ports and the queue fills, after which req_stall rises.
`default_nettype none
module utf16_to_utf8_transcoder_top
   import u16u8_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_last_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_string_end
);

   logic    push, pop, queue_full, head_valid;
   job_type push_job, head_job;

   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_job      (push_job)
   );

   u16u8_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16u8_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule
`default_nettype wire

[bench/utf16_to_utf8_transcoder_top_tb.sv]
// Self-checking testbench for the UTF-16 to UTF-8 transcoder top level.
`default_nettype none
module utf16_to_utf8_transcoder_top_tb
   import u16u8_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit   = 200000;
   localparam int RandomUnits  = 320;
   localparam int DrainCycles  = 20;
   localparam int HoldOffCycles = 300;
   localparam int ReportLimit  = 10;

   // One directed row: the unit, its end flag and, where typed, the bytes it gives.
   typedef struct packed {
      logic [15:0]         unit;
      logic                last;
      logic                typed;
      logic [2:0]          count;
      logic [8*MaxBytes-1:0] bytes;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       string_end;
   } utf8_beat_type;

   localparam int NumDirected = 25;
   localparam directed_row_type DirectedRows [NumDirected] = '{
      {16'h0000, 1'b0, 1'b1, 3'd1, 48'h000000000000},
      {16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F0000000000},
      {16'h0080, 1'b0, 1'b1, 3'd2, 48'hC28000000000},
      {16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDFBF00000000},
      {16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0A080000000},
      {16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEFBFBF000000},
      {16'hD800, 1'b0, 1'b1, 3'd0, 48'h000000000000},
      {16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF09080800000},
      {16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF48FBFBF0000},
      {16'hDC00, 1'b0, 1'b1, 3'd3, 48'hEDB080000000},
      {16'hD800, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'hD800, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'h0041, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'hE000, 1'b1, 1'b0, 3'd0, 48'h000000000000},
      {16'hD800, 1'b1, 1'b0, 3'd0, 48'h000000000000},
      {16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'h07FF, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'hD855, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'hDE37, 1'b1, 1'b0, 3'd0, 48'h000000000000},
      {16'hD800, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'h0000, 1'b1, 1'b0, 3'd0, 48'h000000000000},
      {16'hAAAA, 1'b0, 1'b0, 3'd0, 48'h000000000000},
      {16'h5555, 1'b1, 1'b0, 3'd0, 48'h000000000000}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_code_unit = 16'h0000;
   logic        req_last_unit = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_end;

   // Predictor state: the low bits of a pending high surrogate.
   logic [9:0]  held_bits = '0;
   logic        held_pending = 1'b0;

   logic [7:0]     unit_bytes [$];
   utf8_beat_type  expected_beats [$];

   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          hold_count = 0;
   logic        quiet_mode = 1'b0;
   logic        pressure_req = 1'b0;
   logic        pressure_done = 1'b0;

   utf16_to_utf8_transcoder_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_unit  (req_code_unit),
      .req_last_unit  (req_last_unit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic append_three(input logic [15:0] value);
      unit_bytes.push_back({4'b1110, value[15:12]});
      unit_bytes.push_back({2'b10, value[11:6]});
      unit_bytes.push_back({2'b10, value[5:0]});
   endtask

   // Works out the UTF-8 bytes that one accepted code unit causes.
   task automatic encode_unit(input logic [15:0] cu, input logic lu);
      logic        is_high;
      logic        is_low;
      logic [20:0] code_point;
      is_high = (cu >= 16'hD800) && (cu < 16'hDC00);
      is_low  = (cu >= 16'hDC00) && (cu < 16'hE000);
      unit_bytes.delete();
      if (held_pending && is_low) begin
         code_point = 21'h10000 + {1'b0, held_bits, cu[9:0]};
         unit_bytes.push_back({5'b11110, code_point[20:18]});
         unit_bytes.push_back({2'b10, code_point[17:12]});
         unit_bytes.push_back({2'b10, code_point[11:6]});
         unit_bytes.push_back({2'b10, code_point[5:0]});
         held_pending = 1'b0;
         held_bits = '0;
      end else begin
         if (held_pending) begin
            append_three({6'b110110, held_bits});
            held_pending = 1'b0;
            held_bits = '0;
         end
         if (cu < 16'h0080) begin
            unit_bytes.push_back(cu[7:0]);
         end else if (cu < 16'h0800) begin
            unit_bytes.push_back({3'b110, cu[10:6]});
            unit_bytes.push_back({2'b10, cu[5:0]});
         end else if (is_high && !lu) begin
            held_bits = cu[9:0];
            held_pending = 1'b1;
         end else begin
            append_three(cu);
         end
      end
      if (lu) begin
         held_pending = 1'b0;
         held_bits = '0;
      end
   endtask

   task automatic queue_unit_bytes(input logic lu);
      int n;
      n = unit_bytes.size();
      for (int k = 0; k < n; k++) begin
         expected_beats.push_back({unit_bytes[k], k == n - 1, (k == n - 1) && lu});
      end
   endtask

   // Offers one unit and returns at the edge where it is accepted.
   task automatic offer_unit(input logic [15:0] cu, input logic lu);
      if (!quiet_mode) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_code_unit <= cu;
      req_last_unit <= lu;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic transfer_unit(input logic [15:0] cu, input logic lu);
      offer_unit(cu, lu);
      encode_unit(cu, lu);
      queue_unit_bytes(lu);
   endtask

   // Mostly well-formed text, with lone and reversed surrogates mixed in.
   task automatic send_random_text(inout int sent);
      int          kind;
      logic [15:0] cu;
      logic        lu;
      kind = $urandom_range(99);
      lu = ($urandom_range(7) == 0);
      if (kind < 20) begin
         cu = 16'($urandom_range(16'h007F));
      end else if (kind < 40) begin
         cu = 16'($urandom_range(16'h07FF, 16'h0080));
      end else if (kind < 60) begin
         if ($urandom_range(1) == 1) begin
            cu = 16'($urandom_range(16'hD7FF, 16'h0800));
         end else begin
            cu = 16'($urandom_range(16'hFFFF, 16'hE000));
         end
      end else if (kind < 80) begin
         transfer_unit({6'b110110, 10'($urandom)}, $urandom_range(15) == 0);
         sent++;
         cu = {6'b110111, 10'($urandom)};
      end else if (kind < 90) begin
         cu = {6'b110110, 10'($urandom)};
      end else if (kind < 95) begin
         cu = {6'b110111, 10'($urandom)};
      end else begin
         cu = 16'($urandom);
      end
      transfer_unit(cu, lu);
      sent++;
   endtask

   // Receiver: random stalls, a quiet stretch and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count - 1;
      end else if (pressure_req && !pressure_done) begin
         rsp_stall <= 1'b1;
         hold_count <= HoldOffCycles;
         pressure_done <= 1'b1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 30);
      end
   end

   // Output checker and run watchdog.
   always @(posedge clock) begin
      utf8_beat_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("utf16_to_utf8_transcoder_top regression: fail");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            if (mismatch_count < ReportLimit) begin
               $display("unexpected beat: byte %02h run_last %0b string_end %0b",
                        rsp_out_byte, rsp_run_last, rsp_string_end);
            end
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_out_byte !== want.data || rsp_run_last !== want.run_last ||
                rsp_string_end !== want.string_end) begin
               if (mismatch_count < ReportLimit) begin
                  $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                           want.data, want.run_last, want.string_end,
                           rsp_out_byte, rsp_run_last, rsp_string_end);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int sent;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[i]) begin
         offer_unit(DirectedRows[i].unit, DirectedRows[i].last);
         encode_unit(DirectedRows[i].unit, DirectedRows[i].last);
         if (DirectedRows[i].typed) begin
            unit_bytes.delete();
            for (int k = 0; k < DirectedRows[i].count; k++) begin
               unit_bytes.push_back(DirectedRows[i].bytes[8*(MaxBytes-1-k) +: 8]);
            end
         end
         queue_unit_bytes(DirectedRows[i].last);
      end

      while (sent < RandomUnits) begin
         // A stretch with no idling, then a long receiver hold-off under full load.
         quiet_mode = (sent >= 120) && (sent < 240);
         if (sent >= 200 && sent < 240) begin
            pressure_req <= 1'b1;
         end
         send_random_text(sent);
      end
      transfer_unit(16'h0041, 1'b1);
      req_valid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("utf16_to_utf8_transcoder_top regression: pass");
      end else begin
         $display("utf16_to_utf8_transcoder_top regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

[utf16_to_utf8_transcoder_top.f]
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_front.sv
rtl/core/u16u8_queue.sv
rtl/core/u16u8_back.sv
rtl/core/utf16_to_utf8_transcoder_top.sv
bench/utf16_to_utf8_transcoder_top_tb.sv
